@@ design/ble_pkg.sv @@
// shared types, constants and helper functions for the bitmap line pixel expander
// no dependencies; used by every module of the block
package ble_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int COORD_BITS_DEF      = 12;
  localparam int QUEUE_DEPTH         = 4;
  localparam int SLOTS               = 8;

  // operation codes of an input item
  localparam logic [1:0] OP_DATA  = 2'd0;
  localparam logic [1:0] OP_PAL   = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  // draw_mode bit positions
  localparam int MODE_TRANS = 0;
  localparam int MODE_XOR   = 1;
  localparam int MODE_PAL   = 2;

  typedef enum logic [2:0] {
    REG_BPP          = 3'd0,
    REG_MODE         = 3'd1,
    REG_ORIGIN_X     = 3'd2,
    REG_ORIGIN_Y     = 3'd3,
    REG_ROW_WIDTH    = 3'd4,
    REG_ROW_COUNT    = 3'd5,
    REG_ROW_STRIDE   = 3'd6,
    REG_START_OFFSET = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    DEP_1,
    DEP_2,
    DEP_4,
    DEP_8,
    DEP_16,
    DEP_NONE
  } depth_t;

  typedef enum logic {
    CMD_PAL_WR,
    CMD_PIXELS
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  data_byte;
    logic [7:0]  palette_index;
    logic [15:0] palette_color;
  } in_item_t;

  typedef struct packed {
    logic [12:0] pixel_x;
    logic [12:0] pixel_y;
    logic [15:0] pixel_color;
    logic        invert;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [4:0]  bits_per_pixel;
    logic [2:0]  draw_mode;
    logic [11:0] origin_x;
    logic [11:0] origin_y;
    logic [11:0] row_width;
    logic [11:0] row_count;
    logic [12:0] row_stride;
    logic [2:0]  start_offset;
  } cfg_t;

  // one queued command: a palette write or a byte worth of pixels
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  mask;
    logic [12:0] xbase;
    logic [12:0] ypos;
    logic [15:0] data;
    logic [7:0]  pidx;
  } cmd_t;

  function automatic depth_t depth_of(input logic [4:0] bpp);
    depth_t d;
    case (bpp)
      5'd1:    d = DEP_1;
      5'd2:    d = DEP_2;
      5'd4:    d = DEP_4;
      5'd8:    d = DEP_8;
      5'd16:   d = DEP_16;
      default: d = DEP_NONE;
    endcase
    return d;
  endfunction

  // pixel index held in a slot, most significant pixel first
  function automatic logic [7:0] slot_index(input logic [7:0] b, input depth_t d,
                                            input logic [2:0] s);
    logic [7:0] r;
    r = '0;
    case (d)
      DEP_1: r = {7'd0, b[3'd7 - s]};
      DEP_2: begin
        case (s[1:0])
          2'd0:    r = {6'd0, b[7:6]};
          2'd1:    r = {6'd0, b[5:4]};
          2'd2:    r = {6'd0, b[3:2]};
          default: r = {6'd0, b[1:0]};
        endcase
      end
      DEP_4:   r = s[0] ? {4'd0, b[3:0]} : {4'd0, b[7:4]};
      DEP_8:   r = b;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] lowest_slot(input logic [7:0] m);
    logic [2:0] r;
    r = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (m[i]) r = 3'(i);
    end
    return r;
  endfunction

endpackage

@@ design/ble_front.sv @@
// front end: accepts items, tracks row and column position, builds pixel masks
// depends on ble_pkg
module ble_front #(
  parameter int PALETTE_ENTRIES = ble_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ble_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  ble_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output ble_pkg::cmd_t     q_cmd
);

  logic [11:0] cc_r, cc_nxt;
  logic [11:0] rn_r, rn_nxt;
  logic [12:0] bir_r, bir_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        flag_r, flag_nxt;

  logic            accept;
  ble_pkg::depth_t depth;
  logic [3:0]      ppb;
  logic [2:0]      slot_mask;
  logic [2:0]      diff;
  logic [2:0]      s0;
  logic [11:0]     remaining;
  logic [3:0]      avail;
  logic [3:0]      cnt;
  logic [7:0]      mask;
  logic [7:0]      idx;
  logic [3:0]      rel;
  logic            cond;
  logic [15:0]     v16;
  logic            emit16;
  logic [12:0]     bir_inc;
  logic [12:0]     stride_eff;
  logic            trans;
  logic            xorm;
  logic            pidx_ok;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign trans    = cfg.draw_mode[ble_pkg::MODE_TRANS];
  assign xorm     = cfg.draw_mode[ble_pkg::MODE_XOR];
  assign pidx_ok  = {1'b0, in_data.palette_index} < 9'(PALETTE_ENTRIES);

  always_comb begin
    depth = ble_pkg::depth_of(cfg.bits_per_pixel);
    case (depth)
      ble_pkg::DEP_1: ppb = 4'd8;
      ble_pkg::DEP_2: ppb = 4'd4;
      ble_pkg::DEP_4: ppb = 4'd2;
      default:        ppb = 4'd1;
    endcase
    slot_mask = 3'(ppb - 4'd1);
    diff      = cfg.start_offset & slot_mask;
    s0        = (bir_r == '0) ? diff : 3'd0;
    remaining = (cc_r < cfg.row_width) ? (cfg.row_width - cc_r) : 12'd0;
    avail     = ppb - {1'b0, s0};
    cnt       = (remaining < {8'd0, avail}) ? remaining[3:0] : avail;

    // one mask bit per slot that really writes a pixel
    mask = '0;
    for (int s = 0; s < ble_pkg::SLOTS; s++) begin
      idx = ble_pkg::slot_index(in_data.data_byte, depth, 3'(s));
      rel = 4'(s) - {1'b0, s0};
      if (depth == ble_pkg::DEP_1) begin
        cond = (trans || xorm) ? (idx != '0) : 1'b1;
      end else begin
        cond = !(trans && idx == '0);
      end
      mask[s] = (3'(s) >= s0) && (rel < cnt) && cond;
    end

    v16    = {in_data.data_byte, held_r};
    emit16 = flag_r && (cc_r < cfg.row_width) && !(trans && v16 == '0);

    stride_eff = (cfg.row_stride == '0) ? 13'd1 : cfg.row_stride;
    bir_inc    = bir_r + 13'd1;

    cc_nxt   = cc_r;
    rn_nxt   = rn_r;
    bir_nxt  = bir_r;
    held_nxt = held_r;
    flag_nxt = flag_r;
    q_push   = 1'b0;
    q_cmd.kind  = ble_pkg::CMD_PIXELS;
    q_cmd.mask  = mask;
    q_cmd.xbase = 13'(cfg.origin_x) + 13'(diff) + 13'(cc_r) - 13'(s0);
    q_cmd.ypos  = 13'(cfg.origin_y) + 13'(rn_r);
    q_cmd.data  = {8'd0, in_data.data_byte};
    q_cmd.pidx  = in_data.palette_index;

    if (accept) begin
      case (in_data.operation)
        ble_pkg::OP_PAL: begin
          q_cmd.kind = ble_pkg::CMD_PAL_WR;
          q_cmd.data = in_data.palette_color;
          q_push     = pidx_ok;
        end
        ble_pkg::OP_START: begin
          cc_nxt   = '0;
          rn_nxt   = '0;
          bir_nxt  = '0;
          held_nxt = '0;
          flag_nxt = 1'b0;
        end
        ble_pkg::OP_DATA: begin
          if (depth != ble_pkg::DEP_NONE && rn_r < cfg.row_count) begin
            if (depth == ble_pkg::DEP_16) begin
              if (!flag_r) begin
                held_nxt = in_data.data_byte;
                flag_nxt = 1'b1;
              end else begin
                flag_nxt = 1'b0;
                if (cc_r < cfg.row_width) begin
                  cc_nxt = cc_r + 12'd1;
                end
                q_push      = emit16;
                q_cmd.mask  = 8'd1;
                q_cmd.xbase = 13'(cfg.origin_x) + 13'(cc_r);
                q_cmd.data  = v16;
              end
            end else begin
              cc_nxt = cc_r + {8'd0, cnt};
              q_push = |mask;
            end
            // row ends after stride bytes
            if (bir_inc >= stride_eff) begin
              bir_nxt  = '0;
              cc_nxt   = '0;
              flag_nxt = 1'b0;
              held_nxt = '0;
              rn_nxt   = (rn_r == 12'hFFF) ? 12'hFFF : rn_r + 12'd1;
            end else begin
              bir_nxt = bir_inc;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r   <= '0;
      rn_r   <= '0;
      bir_r  <= '0;
      held_r <= '0;
      flag_r <= 1'b0;
    end else begin
      cc_r   <= cc_nxt;
      rn_r   <= rn_nxt;
      bir_r  <= bir_nxt;
      held_r <= held_nxt;
      flag_r <= flag_nxt;
    end
  end

endmodule

@@ design/ble_queue.sv @@
// short command queue between the front end and the pixel back end
// depends on ble_pkg
module ble_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ble_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output ble_pkg::cmd_t head
);

  localparam int Depth = ble_pkg::QUEUE_DEPTH;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW    = $clog2(Depth + 1);

  ble_pkg::cmd_t entry_r [Depth];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full  = (count_r == CW'(Depth));
  assign empty = (count_r == '0);
  assign head  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ design/ble_back.sv @@
// back end: walks each command's pixel mask one pixel a cycle unless out_stall holds it,
// owns the palette memory and the output register; depends on ble_pkg
module ble_back #(
  parameter int PALETTE_ENTRIES = ble_pkg::PALETTE_ENTRIES_DEF,
  parameter int COORD_BITS      = ble_pkg::COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ble_pkg::cfg_t      cfg,
  input  logic               q_empty,
  input  ble_pkg::cmd_t      q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output ble_pkg::out_item_t out_data
);

  localparam int PalAw = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam logic [12:0] CoordMask = 13'((64'd1 << (COORD_BITS + 1)) - 64'd1);

  logic [15:0] pal_mem [PALETTE_ENTRIES];

  logic        started_r, started_nxt;
  logic [7:0]  mask_r, mask_nxt;
  logic        b_valid_r;
  logic [12:0] b_x_r;
  logic [12:0] b_y_r;
  logic [15:0] b_raw_r;
  logic        b_usepal_r;
  logic        b_inrange_r;
  logic        b_inv_r;
  logic        b_last_r;
  logic [15:0] rd_q_r;

  ble_pkg::depth_t depth;
  logic            advance;
  logic            is_pix;
  logic            is_wr;
  logic            fire;
  logic [7:0]      cur_mask;
  logic [2:0]      slot;
  logic [7:0]      rest;
  logic [7:0]      idx;
  logic [7:0]      addr;
  logic            usepal;
  logic            inv;
  logic [15:0]     raw;
  logic            inrange;

  assign depth    = ble_pkg::depth_of(cfg.bits_per_pixel);
  assign advance  = !b_valid_r || !out_stall;
  assign is_pix   = !q_empty && q_head.kind == ble_pkg::CMD_PIXELS;
  assign is_wr    = !q_empty && q_head.kind == ble_pkg::CMD_PAL_WR;
  assign fire     = is_pix && advance;
  assign cur_mask = started_r ? mask_r : q_head.mask;
  assign slot     = ble_pkg::lowest_slot(cur_mask);
  assign rest     = cur_mask & ~(8'd1 << slot);
  assign q_pop    = is_wr || (fire && rest == '0);
  assign inrange  = {1'b0, addr} < 9'(PALETTE_ENTRIES);

  // pixel classification for the slot being emitted
  always_comb begin
    idx    = ble_pkg::slot_index(q_head.data[7:0], depth, slot);
    addr   = idx;
    usepal = 1'b0;
    inv    = 1'b0;
    raw    = {8'd0, idx};
    case (depth)
      ble_pkg::DEP_16: begin
        raw = q_head.data;
      end
      ble_pkg::DEP_1: begin
        if (cfg.draw_mode[ble_pkg::MODE_TRANS]) begin
          addr   = 8'd1;
          usepal = 1'b1;
        end else if (cfg.draw_mode[ble_pkg::MODE_XOR]) begin
          inv = 1'b1;
          raw = '0;
        end else begin
          usepal = 1'b1;
        end
      end
      default: begin
        usepal = cfg.draw_mode[ble_pkg::MODE_PAL];
      end
    endcase
  end

  always_comb begin
    started_nxt = started_r;
    mask_nxt    = mask_r;
    if (fire) begin
      started_nxt = (rest != '0);
      mask_nxt    = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      mask_r    <= '0;
      b_valid_r <= 1'b0;
    end else begin
      started_r <= started_nxt;
      mask_r    <= mask_nxt;
      if (advance) begin
        b_valid_r <= fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      b_x_r       <= (q_head.xbase + {10'd0, slot}) & CoordMask;
      b_y_r       <= q_head.ypos & CoordMask;
      b_raw_r     <= raw;
      b_usepal_r  <= usepal;
      b_inrange_r <= inrange;
      b_inv_r     <= inv;
      b_last_r    <= (rest == '0);
    end
  end

  // palette: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (is_wr) begin
      pal_mem[q_head.pidx[PalAw-1:0]] <= q_head.data;
    end
    if (fire) begin
      rd_q_r <= pal_mem[addr[PalAw-1:0]];
    end
  end

  assign out_valid            = b_valid_r;
  assign out_data.pixel_x     = b_x_r;
  assign out_data.pixel_y     = b_y_r;
  assign out_data.pixel_color = b_usepal_r ? (b_inrange_r ? rd_q_r : 16'd0) : b_raw_r;
  assign out_data.invert      = b_inv_r;
  assign out_data.last        = b_last_r;

endmodule

@@ design/bitmap_line_pixel_expander.sv @@
// Bitmap line pixel expander, top level; depends on ble_pkg, ble_front, ble_queue
// and ble_back. Each input item carries one packed source byte, a palette write or
// a start-of-bitmap mark; the front end takes one item every cycle while the
// queue is not full, works out the row and column position and which slots of
// the byte write a pixel, and queues a command. The back end emits one pixel
// command per cycle unless out_stall holds it; the queue lets the front end take
// new items before the back end is through with the last. The single palette
// read port in the back end sets that rate. Results pass through the command
// queue and then the back end's output register. The palette holds no valid bits;
// entries read before they are written are undefined. The user must write
// configuration registers through the cfg port while idle; this is not checked.
module bitmap_line_pixel_expander #(
  parameter int PALETTE_ENTRIES = ble_pkg::PALETTE_ENTRIES_DEF,
  parameter int COORD_BITS      = ble_pkg::COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ble_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ble_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [12:0]        cfg_data
);

  ble_pkg::cfg_t cfg_r, cfg_nxt;
  ble_pkg::cmd_t q_cmd;
  ble_pkg::cmd_t q_head;
  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (ble_pkg::cfg_reg_t'(cfg_index))
        ble_pkg::REG_BPP:          cfg_nxt.bits_per_pixel = cfg_data[4:0];
        ble_pkg::REG_MODE:         cfg_nxt.draw_mode      = cfg_data[2:0];
        ble_pkg::REG_ORIGIN_X:     cfg_nxt.origin_x       = cfg_data[11:0];
        ble_pkg::REG_ORIGIN_Y:     cfg_nxt.origin_y       = cfg_data[11:0];
        ble_pkg::REG_ROW_WIDTH:    cfg_nxt.row_width      = cfg_data[11:0];
        ble_pkg::REG_ROW_COUNT:    cfg_nxt.row_count      = cfg_data[11:0];
        ble_pkg::REG_ROW_STRIDE:   cfg_nxt.row_stride     = cfg_data;
        ble_pkg::REG_START_OFFSET: cfg_nxt.start_offset   = cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bits_per_pixel <= 5'd1;
      cfg_r.draw_mode      <= 3'd4;
      cfg_r.origin_x       <= '0;
      cfg_r.origin_y       <= '0;
      cfg_r.row_width      <= 12'd1;
      cfg_r.row_count      <= 12'd1;
      cfg_r.row_stride     <= 13'd1;
      cfg_r.start_offset   <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ble_front #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  ble_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  ble_back #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES),
    .COORD_BITS     (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // the front end never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command pushed into full queue");

  // the back end never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("command popped from empty queue");

  // invert commands carry no color
  a_invert_color: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.invert) |-> (out_data.pixel_color == 16'd0))
    else $error("invert command with nonzero color");

endmodule
